@@ rtl/three_way_quicksort_engine_top_defines.svh @@
// Assertion macros for the quicksort engine controller.
// No dependencies; the including module must provide clk and arst_n.
`ifndef THREE_WAY_QUICKSORT_ENGINE_TOP_DEFINES_SVH
`define THREE_WAY_QUICKSORT_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define TWQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk and disabled during reset.
`define TWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TWQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TWQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/twqs_pkg.sv @@
// Types and constants shared by the quicksort engine modules.
// No dependencies.
package twqs_pkg;

	localparam int KEY_W       = 32;
	localparam int TAG_W       = 16;
	localparam int ITEM_W      = KEY_W + TAG_W;
	localparam int STACK_SLOTS = 7;
	localparam int DEPTH_W     = 3;
	localparam int LIM_W       = 8;

	// Controller states.
	typedef enum logic [4:0] {
		S_LOAD, S_START, S_INS_M, S_INS_RD, S_INS_EV, S_CHK_RD, S_CHK_EV,
		S_PIV_SET, S_MED1, S_MED2, S_MED3, S_MED4, S_SW_RD, S_SW_W1, S_SW_W2,
		S_PART_INIT, S_P1_RD, S_P1_EV, S_P2_RD, S_P2_EV, S_P3, S_BS_INIT,
		S_BS_LOOP, S_DECIDE, S_POP, S_EMIT_RD, S_EMIT
	} state_t;

	// Source of the store's write data.
	typedef enum logic [1:0] {
		WR_IN, WR_A, WR_B
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    rd_en;
		logic    wr_en;
		wr_sel_t wr_sel;
	} dp_cmd_t;

	// Key comparison of read port A against read port B.
	typedef struct packed {
		logic key_lt;
		logic key_gt;
	} dp_status_t;

endpackage

@@ rtl/three_way_quicksort_engine_top.sv @@
// Top level of the three-way quicksort engine: controller plus datapath.
// Depends on twqs_pkg, twqs_ctrl and twqs_dp.
//
//  Channel  Direction  Word contents
//  s_*      in         tdata: sort_key[31:0], payload_tag[47:32]; tlast: final_item
//  m_*      out        tdata: sorted_key[31:0], sorted_tag[47:32]; tlast: end_of_run
//
// Loading accepts one word per cycle. A single compare reads, then evaluates; a median
// of three reads its pairs in turn, and a swap reads both items, then writes each back,
// all set by the single store's two read ports and one write port. Emission reads
// each word, then holds it on m_* until m_tready.
// No input word is taken from the final word until the last sorted word leaves.
// Reset clears the controller; the store itself is not cleared.
module three_way_quicksort_engine_top import twqs_pkg::*; #(
	parameter int MAX_ITEMS     = 64,
	parameter int SMALL_LIMIT   = 7,
	parameter int NINTHER_LIMIT = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ITEM_W-1:0] s_tdata,  // sort_key[31:0], payload_tag[47:32]
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ITEM_W-1:0] m_tdata,  // sorted_key[31:0], sorted_tag[47:32]
	output logic              m_tlast
);

	localparam int AW = $clog2(MAX_ITEMS);

	dp_cmd_t       cmd;
	dp_status_t    status;
	logic [AW-1:0] rd_a, rd_b, wr_addr;

	twqs_ctrl #(
		.MAX_ITEMS    (MAX_ITEMS),
		.SMALL_LIMIT  (SMALL_LIMIT),
		.NINTHER_LIMIT(NINTHER_LIMIT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tlast (m_tlast),
		.cmd     (cmd),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.wr_addr (wr_addr),
		.status  (status)
	);

	twqs_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk    (clk),
		.cmd    (cmd),
		.rd_a   (rd_a),
		.rd_b   (rd_b),
		.wr_addr(wr_addr),
		.in_key (s_tdata[KEY_W-1:0]),
		.in_tag (s_tdata[ITEM_W-1:KEY_W]),
		.item_a (m_tdata),
		.status (status)
	);

endmodule

@@ rtl/twqs_dp.sv @@
// Datapath: item store with two registered read ports, one write port, key comparator.
// Depends on twqs_pkg.
module twqs_dp import twqs_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                         clk,
	input  dp_cmd_t                      cmd,
	input  logic [$clog2(MAX_ITEMS)-1:0] rd_a,
	input  logic [$clog2(MAX_ITEMS)-1:0] rd_b,
	input  logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
	input  logic [KEY_W-1:0]             in_key,
	input  logic [TAG_W-1:0]             in_tag,
	output logic [ITEM_W-1:0]            item_a,
	output dp_status_t                   status
);

	logic [ITEM_W-1:0] mem [MAX_ITEMS];
	logic [ITEM_W-1:0] ra_q;
	logic [ITEM_W-1:0] rb_q;
	logic [ITEM_W-1:0] wdata;

	// Write data selection; an item holds the key in its low bits.
	always_comb begin
		case (cmd.wr_sel)
			WR_IN:   wdata = {in_tag, in_key};
			WR_A:    wdata = ra_q;
			WR_B:    wdata = rb_q;
			default: wdata = ra_q;
		endcase
	end

	// Store with registered reads; read registers hold until the next read.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			ra_q <= mem[rd_a];
			rb_q <= mem[rd_b];
		end
	end

	// Unsigned key comparison of the two read registers.
	always_comb begin
		status.key_lt = ra_q[KEY_W-1:0] < rb_q[KEY_W-1:0];
		status.key_gt = ra_q[KEY_W-1:0] > rb_q[KEY_W-1:0];
	end

	assign item_a = ra_q;

endmodule

@@ rtl/twqs_ctrl.sv @@
// Controller: load, quicksort sequencer with partition stack, and emission.
// Depends on twqs_pkg and the assertion macro header.
`include "three_way_quicksort_engine_top_defines.svh"
module twqs_ctrl import twqs_pkg::*; #(
	parameter int MAX_ITEMS     = 64,
	parameter int SMALL_LIMIT   = 7,
	parameter int NINTHER_LIMIT = 40
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic                         m_tlast,
	output dp_cmd_t                      cmd,
	output logic [$clog2(MAX_ITEMS)-1:0] rd_a,
	output logic [$clog2(MAX_ITEMS)-1:0] rd_b,
	output logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
	input  dp_status_t                   status
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int IW = $clog2(MAX_ITEMS + 1);
	localparam logic [IW-1:0] ONE = IW'(1);
	localparam logic [IW-1:0] MAXN = IW'(MAX_ITEMS);

	state_t state_q, state_d, ret_q, ret_d;
	logic [IW-1:0] cnt_q, cnt_d, lo_q, lo_d, n_q, n_d, m_q, m_d, l_q, l_d, k_q, k_d;
	logic [IW-1:0] pa_q, pa_d, pb_q, pb_d, pc_q, pc_d, pd_q, pd_d;
	logic [IW-1:0] sw_i_q, sw_i_d, sw_j_q, sw_j_d;
	logic [IW-1:0] ta_q, ta_d, tb_q, tb_d, tc_q, tc_d;
	logic [IW-1:0] piv_q [3];
	logic [IW-1:0] piv_d [3];
	logic [IW-1:0] bs_i_q, bs_i_d, bs_j_q, bs_j_d, bs_cnt_q, bs_cnt_d;
	logic          bs_second_q, bs_second_d;
	logic [1:0]    j_q, j_d;
	logic          ab_lt_q, ab_lt_d, bc_lt_q, bc_lt_d, bc_gt_q, bc_gt_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [IW-1:0] stk_lo_q [STACK_SLOTS];
	logic [IW-1:0] stk_lo_d [STACK_SLOTS];
	logic [IW-1:0] stk_n_q [STACK_SLOTS];
	logic [IW-1:0] stk_n_d [STACK_SLOTS];

	logic [IW-1:0] hi, mid, last, dn, med, a1, b1, a2, b2, d1, d2, s_lo, s_n, b_lo, b_n;
	logic [LIM_W-1:0] n_w;

	// Range bounds and partition bookkeeping derived from the index registers.
	always_comb begin
		hi   = lo_q + n_q;
		mid  = lo_q + (n_q >> 1);
		last = hi - ONE;
		dn   = n_q >> 3;
		n_w  = LIM_W'(n_q);
		med  = ab_lt_q ? (bc_lt_q ? tb_q : (status.key_lt ? tc_q : ta_q))
			: (bc_gt_q ? tb_q : (status.key_lt ? ta_q : tc_q));
		a1 = pa_q - lo_q;
		b1 = pb_q - pa_q;
		a2 = pd_q - pc_q;
		b2 = hi - pd_q - ONE;
		d1 = b1;
		d2 = a2;
		if (d1 <= d2) begin
			s_lo = lo_q;
			s_n  = d1;
			b_lo = hi - d2;
			b_n  = d2;
		end else begin
			s_lo = hi - d2;
			s_n  = d2;
			b_lo = lo_q;
			b_n  = d1;
		end
	end

	// Next state and outputs.
	always_comb begin
		state_d = state_q; ret_d = ret_q; cnt_d = cnt_q; lo_d = lo_q; n_d = n_q;
		m_d = m_q; l_d = l_q; k_d = k_q; pa_d = pa_q; pb_d = pb_q; pc_d = pc_q;
		pd_d = pd_q; sw_i_d = sw_i_q; sw_j_d = sw_j_q; ta_d = ta_q; tb_d = tb_q;
		tc_d = tc_q; piv_d = piv_q; bs_i_d = bs_i_q; bs_j_d = bs_j_q;
		bs_cnt_d = bs_cnt_q; bs_second_d = bs_second_q; j_d = j_q;
		ab_lt_d = ab_lt_q; bc_lt_d = bc_lt_q; bc_gt_d = bc_gt_q; depth_d = depth_q;
		stk_lo_d = stk_lo_q; stk_n_d = stk_n_q;
		cmd = '0; rd_a = '0; rd_b = '0; wr_addr = '0;
		s_tready = 1'b0; m_tvalid = 1'b0; m_tlast = 1'b0;
		case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (cnt_q < MAXN) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_IN;
						wr_addr    = cnt_q[AW-1:0];
						cnt_d      = cnt_q + ONE;
					end
					if (s_tlast) begin
						lo_d    = '0;
						n_d     = (cnt_q < MAXN) ? cnt_q + ONE : cnt_q;
						depth_d = '0;
						state_d = S_START;
					end
				end
			end
			S_START: begin
				m_d     = lo_q + ONE;
				state_d = (n_w < LIM_W'(SMALL_LIMIT)) ? S_INS_M : S_CHK_RD;
			end
			// Insertion sort of a short range.
			S_INS_M: begin
				if (m_q >= hi) begin
					state_d = S_POP;
				end else begin
					l_d     = m_q;
					state_d = S_INS_RD;
				end
			end
			S_INS_RD: begin
				if (l_q > lo_q) begin
					cmd.rd_en = 1'b1;
					rd_a      = AW'(l_q - ONE);
					rd_b      = l_q[AW-1:0];
					state_d   = S_INS_EV;
				end else begin
					m_d     = m_q + ONE;
					state_d = S_INS_M;
				end
			end
			S_INS_EV: begin
				if (status.key_gt) begin
					sw_i_d  = l_q;
					sw_j_d  = l_q - ONE;
					l_d     = l_q - ONE;
					ret_d   = S_INS_RD;
					state_d = S_SW_RD;
				end else begin
					m_d     = m_q + ONE;
					state_d = S_INS_M;
				end
			end
			// Skip a range that is already in order.
			S_CHK_RD: begin
				if (m_q < hi) begin
					cmd.rd_en = 1'b1;
					rd_a      = AW'(m_q - ONE);
					rd_b      = m_q[AW-1:0];
					state_d   = S_CHK_EV;
				end else begin
					state_d = S_POP;
				end
			end
			S_CHK_EV: begin
				if (status.key_gt) begin
					if (n_w > LIM_W'(NINTHER_LIMIT)) begin
						j_d     = 2'd0;
						state_d = S_PIV_SET;
					end else if (n_w > LIM_W'(SMALL_LIMIT)) begin
						j_d     = 2'd3;
						state_d = S_PIV_SET;
					end else begin
						sw_i_d  = lo_q;
						sw_j_d  = mid;
						ret_d   = S_PART_INIT;
						state_d = S_SW_RD;
					end
				end else begin
					m_d     = m_q + ONE;
					state_d = S_CHK_RD;
				end
			end
			// Pivot: median of three medians if large, else of lo, mid, last.
			S_PIV_SET: begin
				case (j_q)
					2'd0: begin
						ta_d = lo_q; tb_d = lo_q + dn; tc_d = lo_q + dn + dn;
					end
					2'd1: begin
						ta_d = mid - dn; tb_d = mid; tc_d = mid + dn;
					end
					2'd2: begin
						ta_d = last - dn - dn; tb_d = last - dn; tc_d = last;
					end
					default: begin
						if (n_w > LIM_W'(NINTHER_LIMIT)) begin
							ta_d = piv_q[0]; tb_d = piv_q[1]; tc_d = piv_q[2];
						end else begin
							ta_d = lo_q; tb_d = mid; tc_d = last;
						end
					end
				endcase
				state_d = S_MED1;
			end
			S_MED1: begin
				cmd.rd_en = 1'b1;
				rd_a      = ta_q[AW-1:0];
				rd_b      = tb_q[AW-1:0];
				state_d   = S_MED2;
			end
			S_MED2: begin
				ab_lt_d   = status.key_lt;
				cmd.rd_en = 1'b1;
				rd_a      = tb_q[AW-1:0];
				rd_b      = tc_q[AW-1:0];
				state_d   = S_MED3;
			end
			S_MED3: begin
				bc_lt_d   = status.key_lt;
				bc_gt_d   = status.key_gt;
				cmd.rd_en = 1'b1;
				rd_a      = ta_q[AW-1:0];
				rd_b      = tc_q[AW-1:0];
				state_d   = S_MED4;
			end
			S_MED4: begin
				if (j_q == 2'd3) begin
					sw_i_d  = lo_q;
					sw_j_d  = med;
					ret_d   = S_PART_INIT;
					state_d = S_SW_RD;
				end else begin
					piv_d[j_q] = med;
					j_d        = j_q + 2'd1;
					state_d    = S_PIV_SET;
				end
			end
			// Swap of two items: read both, then write each back crosswise.
			S_SW_RD: begin
				cmd.rd_en = 1'b1;
				rd_a      = sw_i_q[AW-1:0];
				rd_b      = sw_j_q[AW-1:0];
				state_d   = S_SW_W1;
			end
			S_SW_W1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_B;
				wr_addr    = sw_i_q[AW-1:0];
				state_d    = S_SW_W2;
			end
			S_SW_W2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_A;
				wr_addr    = sw_j_q[AW-1:0];
				state_d    = ret_q;
			end
			// Three-way partition around the pivot at the range start.
			S_PART_INIT: begin
				pa_d    = lo_q + ONE;
				pb_d    = lo_q + ONE;
				pc_d    = last;
				pd_d    = last;
				state_d = S_P1_RD;
			end
			S_P1_RD: begin
				if (pb_q <= pc_q) begin
					cmd.rd_en = 1'b1;
					rd_a      = pb_q[AW-1:0];
					rd_b      = lo_q[AW-1:0];
					state_d   = S_P1_EV;
				end else begin
					state_d = S_P2_RD;
				end
			end
			S_P1_EV: begin
				if (status.key_gt) begin
					state_d = S_P2_RD;
				end else if (!status.key_lt) begin
					sw_i_d  = pa_q;
					sw_j_d  = pb_q;
					pa_d    = pa_q + ONE;
					pb_d    = pb_q + ONE;
					ret_d   = S_P1_RD;
					state_d = S_SW_RD;
				end else begin
					pb_d    = pb_q + ONE;
					state_d = S_P1_RD;
				end
			end
			S_P2_RD: begin
				if (pb_q <= pc_q) begin
					cmd.rd_en = 1'b1;
					rd_a      = pc_q[AW-1:0];
					rd_b      = lo_q[AW-1:0];
					state_d   = S_P2_EV;
				end else begin
					state_d = S_P3;
				end
			end
			S_P2_EV: begin
				if (status.key_lt) begin
					state_d = S_P3;
				end else if (!status.key_gt) begin
					sw_i_d  = pc_q;
					sw_j_d  = pd_q;
					pc_d    = pc_q - ONE;
					pd_d    = pd_q - ONE;
					ret_d   = S_P2_RD;
					state_d = S_SW_RD;
				end else begin
					pc_d    = pc_q - ONE;
					state_d = S_P2_RD;
				end
			end
			S_P3: begin
				if (pb_q > pc_q) begin
					state_d = S_BS_INIT;
				end else begin
					sw_i_d  = pb_q;
					sw_j_d  = pc_q;
					pb_d    = pb_q + ONE;
					pc_d    = pc_q - ONE;
					ret_d   = S_P1_RD;
					state_d = S_SW_RD;
				end
			end
			// Move the equal keys from both ends into the middle.
			S_BS_INIT: begin
				bs_cnt_d    = (a1 < b1) ? a1 : b1;
				bs_i_d      = lo_q;
				bs_j_d      = pb_q - ((a1 < b1) ? a1 : b1);
				bs_second_d = 1'b0;
				state_d     = S_BS_LOOP;
			end
			S_BS_LOOP: begin
				if (bs_cnt_q == '0) begin
					if (!bs_second_q) begin
						bs_cnt_d    = (a2 < b2) ? a2 : b2;
						bs_i_d      = pb_q;
						bs_j_d      = hi - ((a2 < b2) ? a2 : b2);
						bs_second_d = 1'b1;
					end else begin
						state_d = S_DECIDE;
					end
				end else begin
					sw_i_d   = bs_i_q;
					sw_j_d   = bs_j_q;
					bs_i_d   = bs_i_q + ONE;
					bs_j_d   = bs_j_q + ONE;
					bs_cnt_d = bs_cnt_q - ONE;
					ret_d    = S_BS_LOOP;
					state_d  = S_SW_RD;
				end
			end
			// If both need sorting, go on with smaller, stack larger if room.
			S_DECIDE: begin
				if (s_n > ONE && b_n > ONE) begin
					if (depth_q < DEPTH_W'(STACK_SLOTS)) begin
						stk_lo_d[depth_q] = b_lo;
						stk_n_d[depth_q]  = b_n;
						depth_d           = depth_q + DEPTH_W'(1);
					end
					lo_d    = s_lo;
					n_d     = s_n;
					state_d = S_START;
				end else if (b_n > ONE) begin
					lo_d    = b_lo;
					n_d     = b_n;
					state_d = S_START;
				end else if (s_n > ONE) begin
					lo_d    = s_lo;
					n_d     = s_n;
					state_d = S_START;
				end else begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (depth_q == '0) begin
					k_d     = '0;
					state_d = S_EMIT_RD;
				end else begin
					depth_d = depth_q - DEPTH_W'(1);
					lo_d    = stk_lo_q[depth_q - DEPTH_W'(1)];
					n_d     = stk_n_q[depth_q - DEPTH_W'(1)];
					state_d = S_START;
				end
			end
			// Emission of the sorted store in address order.
			S_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				rd_a      = k_q[AW-1:0];
				rd_b      = k_q[AW-1:0];
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				m_tvalid = 1'b1;
				m_tlast  = (k_q == cnt_q - ONE);
				if (m_tready) begin
					if (k_q == cnt_q - ONE) begin
						cnt_d   = '0;
						depth_d = '0;
						state_d = S_LOAD;
					end else begin
						k_d     = k_q + ONE;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// State and index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD; ret_q <= S_LOAD; cnt_q <= '0; lo_q <= '0; n_q <= '0;
			m_q <= '0; l_q <= '0; k_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0;
			pd_q <= '0; sw_i_q <= '0; sw_j_q <= '0; ta_q <= '0; tb_q <= '0;
			tc_q <= '0; piv_q <= '{default: '0}; bs_i_q <= '0; bs_j_q <= '0;
			bs_cnt_q <= '0; bs_second_q <= 1'b0; j_q <= '0; ab_lt_q <= 1'b0;
			bc_lt_q <= 1'b0; bc_gt_q <= 1'b0; depth_q <= '0;
			stk_lo_q <= '{default: '0}; stk_n_q <= '{default: '0};
		end else begin
			state_q <= state_d; ret_q <= ret_d; cnt_q <= cnt_d; lo_q <= lo_d;
			n_q <= n_d; m_q <= m_d; l_q <= l_d; k_q <= k_d; pa_q <= pa_d;
			pb_q <= pb_d; pc_q <= pc_d; pd_q <= pd_d; sw_i_q <= sw_i_d;
			sw_j_q <= sw_j_d; ta_q <= ta_d; tb_q <= tb_d; tc_q <= tc_d;
			piv_q <= piv_d; bs_i_q <= bs_i_d; bs_j_q <= bs_j_d;
			bs_cnt_q <= bs_cnt_d; bs_second_q <= bs_second_d; j_q <= j_d;
			ab_lt_q <= ab_lt_d; bc_lt_q <= bc_lt_d; bc_gt_q <= bc_gt_d;
			depth_q <= depth_d; stk_lo_q <= stk_lo_d; stk_n_q <= stk_n_d;
		end
	end

	// The stack never holds more than its slots.
	`TWQ_ASSERT_IMPLY(a_stack_bound, 1'b1, depth_q <= DEPTH_W'(STACK_SLOTS), "stack overflow")
	// The left scan never passes the right scan by more than one.
	`TWQ_ASSERT_IMPLY(a_scan_order, state_q == S_P1_RD, pb_q <= pc_q + ONE, "scan crossed")
	// Swaps only touch loaded entries.
	`TWQ_ASSERT_IMPLY(a_swap_range, state_q == S_SW_RD, sw_i_q < cnt_q && sw_j_q < cnt_q, "swap out of range")
	// The fill count stays within the store.
	`TWQ_ASSERT_IMPLY(a_count_bound, 1'b1, cnt_q <= MAXN, "count overflow")

endmodule
